// File: rtl/core/bti_pkg.sv
// shared constants, codes and types of the bilinear table interpolator
`timescale 1ns / 1ps
package bti_pkg;

	localparam int MAX_MACH_POINTS = 16;
	localparam int MAX_AOA_POINTS  = 16;
	localparam int FRAC_BITS       = 16;

	localparam int VAL_W     = 32;
	localparam int ACT_W     = 3;
	localparam int ROW_W     = 4;
	localparam int COL_W     = 4;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int FRAC_W    = FRAC_BITS + 1;

	localparam int AX_MAX = (MAX_MACH_POINTS > MAX_AOA_POINTS) ? MAX_MACH_POINTS : MAX_AOA_POINTS;
	localparam int AX_IW  = (AX_MAX > 1) ? $clog2(AX_MAX) : 1;
	localparam int AX_CW  = $clog2(AX_MAX + 1);

	localparam int TBL_DEPTH = MAX_MACH_POINTS * MAX_AOA_POINTS;
	localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	// s1, s2, s3 and one stage per quotient bit
	localparam int AXIS_LAT = 3 + FRAC_BITS;

	localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [ACT_W-1:0] {
		ACT_MACH_PT = 3'd0,
		ACT_AOA_PT  = 3'd1,
		ACT_LIFT    = 3'd2,
		ACT_DRAG    = 3'd3,
		ACT_QUERY   = 3'd4
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MACH_COUNT = 1'b0,
		CFG_AOA_COUNT  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                    en;
		logic [AX_IW-1:0]        idx;
		logic signed [VAL_W-1:0] data;
	} pt_wr_t;

	typedef struct packed {
		logic [AX_IW-1:0]  lo;
		logic [AX_IW-1:0]  hi;
		logic [FRAC_W-1:0] frac;
	} axis_res_t;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [VAL_W-1:0] wv;
		logic                    empty;
	} sb_t;

endpackage

// File: rtl/core/bti_axis.sv
// breakpoint store, bracket search and pipelined fraction divider for one axis
`timescale 1ns / 1ps
module bti_axis import bti_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [VAL_W-1:0] x,
	input  logic [AX_CW-1:0]        n,
	input  pt_wr_t                  wr,
	output axis_res_t               res
);

	logic signed [VAL_W-1:0] pt_q [AX_MAX];
	logic signed [VAL_W-1:0] pt_mem [AX_MAX];
	logic [AX_MAX-1:0]       le;
	logic [AX_IW-1:0]        lo_c;
	logic [AX_IW-1:0]        hi_c;
	logic [AX_CW:0]          nxt;

	logic [AX_IW-1:0]        lo_s1, hi_s1, lo_s2, hi_s2, lo_s3, hi_s3;
	logic signed [VAL_W-1:0] x_s1, x_s2, plo_s2, phi_s2;
	logic signed [VAL_W:0]   num, den;
	logic [VAL_W:0]          rem_s3, den_s3;
	logic                    zero_s3, one_s3;

	// quotient stages, indexed by stage
	logic [VAL_W:0]          div_rem_s [FRAC_BITS];
	logic [VAL_W:0]          div_den_s [FRAC_BITS];
	logic [FRAC_BITS-1:0]    div_q_s [FRAC_BITS];
	logic [AX_IW-1:0]        div_lo_s [FRAC_BITS];
	logic [AX_IW-1:0]        div_hi_s [FRAC_BITS];
	logic                    div_zero_s [FRAC_BITS];
	logic                    div_one_s [FRAC_BITS];

	always_comb begin
		for (int i = 0; i < AX_MAX; i++) begin
			le[i] = (pt_q[i] <= x) && (AX_CW'(i) < n);
		end
		lo_c = '0;
		for (int i = 0; i < AX_MAX; i++) begin
			if (le[i]) begin
				lo_c = AX_IW'(i);
			end
		end
		nxt = {1'b0, AX_CW'(lo_c)} + (AX_CW + 1)'(1);
		if (nxt >= {1'b0, n}) begin
			hi_c = AX_IW'(n - AX_CW'(1));
		end else begin
			hi_c = AX_IW'(nxt);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			pt_q[wr.idx] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			pt_mem[wr.idx] <= wr.data;
		end
		if (en) begin
			plo_s2 <= pt_mem[lo_s1];
			phi_s2 <= pt_mem[hi_s1];
		end
	end

	assign num = $signed({x_s2[VAL_W-1], x_s2}) - $signed({plo_s2[VAL_W-1], plo_s2});
	assign den = $signed({phi_s2[VAL_W-1], phi_s2}) - $signed({plo_s2[VAL_W-1], plo_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= lo_c;
			hi_s1   <= hi_c;
			x_s1    <= x;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			x_s2    <= x_s1;
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
			rem_s3  <= num;
			den_s3  <= den;
			zero_s3 <= (den <= 0) || (num <= 0);
			one_s3  <= num >= den;
		end
	end

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
		logic [VAL_W:0]       src_rem, src_den;
		logic [FRAC_BITS-1:0] src_q;
		logic [AX_IW-1:0]     src_lo, src_hi;
		logic                 src_zero, src_one;
		logic [VAL_W+1:0]     t;
		logic                 ge;

		if (k == 0) begin : g_first
			assign src_rem  = rem_s3;
			assign src_den  = den_s3;
			assign src_q    = '0;
			assign src_lo   = lo_s3;
			assign src_hi   = hi_s3;
			assign src_zero = zero_s3;
			assign src_one  = one_s3;
		end else begin : g_next
			assign src_rem  = div_rem_s[k-1];
			assign src_den  = div_den_s[k-1];
			assign src_q    = div_q_s[k-1];
			assign src_lo   = div_lo_s[k-1];
			assign src_hi   = div_hi_s[k-1];
			assign src_zero = div_zero_s[k-1];
			assign src_one  = div_one_s[k-1];
		end

		assign t  = {src_rem, 1'b0};
		assign ge = t >= {1'b0, src_den};

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[k]  <= ge ? VAL_W'(t - {1'b0, src_den}) + (VAL_W + 1)'(0)
						    : t[VAL_W:0];
				div_den_s[k]  <= src_den;
				div_q_s[k]    <= {src_q[FRAC_BITS-2:0], ge};
				div_lo_s[k]   <= src_lo;
				div_hi_s[k]   <= src_hi;
				div_zero_s[k] <= src_zero;
				div_one_s[k]  <= src_one;
			end
		end
	end

	always_comb begin
		res.lo = div_lo_s[FRAC_BITS-1];
		res.hi = div_hi_s[FRAC_BITS-1];
		if (div_zero_s[FRAC_BITS-1]) begin
			res.frac = '0;
		end else if (div_one_s[FRAC_BITS-1]) begin
			res.frac = FRAC_ONE;
		end else begin
			res.frac = {1'b0, div_q_s[FRAC_BITS-1]};
		end
	end

endmodule

// File: rtl/core/bti_blend.sv
// coefficient table memories and the two-level bilinear blend pipeline
`timescale 1ns / 1ps
module bti_blend import bti_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    live,
	input  sb_t                     sb,
	input  axis_res_t               mres,
	input  axis_res_t               ares,
	output logic                    res_valid,
	output logic signed [VAL_W-1:0] lift,
	output logic signed [VAL_W-1:0] drag,
	output logic                    empty
);

	localparam int PROD_W = VAL_W + FRAC_W + 1;
	localparam int SUM_W  = PROD_W + 1;

	logic signed [VAL_W-1:0] lift_a [TBL_DEPTH];
	logic signed [VAL_W-1:0] lift_b [TBL_DEPTH];
	logic signed [VAL_W-1:0] drag_a [TBL_DEPTH];
	logic signed [VAL_W-1:0] drag_b [TBL_DEPTH];

	logic                    idx_ok, wr_lift, wr_drag;
	logic [TBL_AW-1:0]       waddr, a11, a21, a12, a22;

	logic                    valid_b1, valid_b2, valid_b3, valid_b4, valid_b5;
	logic                    empty_b1, empty_b2, empty_b3, empty_b4, empty_b5;
	logic signed [VAL_W-1:0] l11_b1, l21_b1, l12_b1, l22_b1;
	logic signed [VAL_W-1:0] d11_b1, d21_b1, d12_b1, d22_b1;
	logic [FRAC_W-1:0]       fm_b1, fa_b1, fa_b2, fa_b3;
	logic [FRAC_W-1:0]       wm, wa;
	logic signed [PROD_W-1:0] pl11_b2, pl21_b2, pl12_b2, pl22_b2;
	logic signed [PROD_W-1:0] pd11_b2, pd21_b2, pd12_b2, pd22_b2;
	logic signed [SUM_W-1:0]  sl1, sl2, sd1, sd2;
	logic signed [VAL_W-1:0]  rl1_b3, rl2_b3, rd1_b3, rd2_b3;
	logic signed [PROD_W-1:0] ql1_b4, ql2_b4, qd1_b4, qd2_b4;
	logic signed [SUM_W-1:0]  tl, td;
	logic signed [VAL_W-1:0]  lift_b5, drag_b5;

	assign idx_ok  = (32'(sb.row) < MAX_MACH_POINTS) && (32'(sb.col) < MAX_AOA_POINTS);
	assign wr_lift = en && live && idx_ok && (sb.action == ACT_LIFT);
	assign wr_drag = en && live && idx_ok && (sb.action == ACT_DRAG);
	assign waddr   = TBL_AW'(32'(sb.row) * MAX_AOA_POINTS + 32'(sb.col));
	assign a11     = TBL_AW'(32'(mres.lo) * MAX_AOA_POINTS + 32'(ares.lo));
	assign a21     = TBL_AW'(32'(mres.hi) * MAX_AOA_POINTS + 32'(ares.lo));
	assign a12     = TBL_AW'(32'(mres.lo) * MAX_AOA_POINTS + 32'(ares.hi));
	assign a22     = TBL_AW'(32'(mres.hi) * MAX_AOA_POINTS + 32'(ares.hi));

	always_ff @(posedge clk) begin
		if (wr_lift) begin
			lift_a[waddr] <= sb.wv;
		end
		if (en) begin
			l11_b1 <= lift_a[a11];
			l21_b1 <= lift_a[a21];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_lift) begin
			lift_b[waddr] <= sb.wv;
		end
		if (en) begin
			l12_b1 <= lift_b[a12];
			l22_b1 <= lift_b[a22];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_drag) begin
			drag_a[waddr] <= sb.wv;
		end
		if (en) begin
			d11_b1 <= drag_a[a11];
			d21_b1 <= drag_a[a21];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_drag) begin
			drag_b[waddr] <= sb.wv;
		end
		if (en) begin
			d12_b1 <= drag_b[a12];
			d22_b1 <= drag_b[a22];
		end
	end

	assign wm  = FRAC_ONE - fm_b1;
	assign wa  = FRAC_ONE - fa_b3;
	assign sl1 = SUM_W'(pl11_b2) + SUM_W'(pl21_b2);
	assign sl2 = SUM_W'(pl12_b2) + SUM_W'(pl22_b2);
	assign sd1 = SUM_W'(pd11_b2) + SUM_W'(pd21_b2);
	assign sd2 = SUM_W'(pd12_b2) + SUM_W'(pd22_b2);
	assign tl  = SUM_W'(ql1_b4) + SUM_W'(ql2_b4);
	assign td  = SUM_W'(qd1_b4) + SUM_W'(qd2_b4);

	always_ff @(posedge clk) begin
		if (en) begin
			fm_b1   <= mres.frac;
			fa_b1   <= ares.frac;
			pl11_b2 <= l11_b1 * $signed({1'b0, wm});
			pl21_b2 <= l21_b1 * $signed({1'b0, fm_b1});
			pl12_b2 <= l12_b1 * $signed({1'b0, wm});
			pl22_b2 <= l22_b1 * $signed({1'b0, fm_b1});
			pd11_b2 <= d11_b1 * $signed({1'b0, wm});
			pd21_b2 <= d21_b1 * $signed({1'b0, fm_b1});
			pd12_b2 <= d12_b1 * $signed({1'b0, wm});
			pd22_b2 <= d22_b1 * $signed({1'b0, fm_b1});
			fa_b2   <= fa_b1;
			rl1_b3  <= VAL_W'(sl1 >>> FRAC_BITS);
			rl2_b3  <= VAL_W'(sl2 >>> FRAC_BITS);
			rd1_b3  <= VAL_W'(sd1 >>> FRAC_BITS);
			rd2_b3  <= VAL_W'(sd2 >>> FRAC_BITS);
			fa_b3   <= fa_b2;
			ql1_b4  <= rl1_b3 * $signed({1'b0, wa});
			ql2_b4  <= rl2_b3 * $signed({1'b0, fa_b3});
			qd1_b4  <= rd1_b3 * $signed({1'b0, wa});
			qd2_b4  <= rd2_b3 * $signed({1'b0, fa_b3});
			lift_b5 <= empty_b4 ? '0 : VAL_W'(tl >>> FRAC_BITS);
			drag_b5 <= empty_b4 ? '0 : VAL_W'(td >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
			valid_b3 <= 1'b0;
			valid_b4 <= 1'b0;
			valid_b5 <= 1'b0;
			empty_b1 <= 1'b0;
			empty_b2 <= 1'b0;
			empty_b3 <= 1'b0;
			empty_b4 <= 1'b0;
			empty_b5 <= 1'b0;
		end else if (en) begin
			valid_b1 <= live && (sb.action == ACT_QUERY);
			valid_b2 <= valid_b1;
			valid_b3 <= valid_b2;
			valid_b4 <= valid_b3;
			valid_b5 <= valid_b4;
			empty_b1 <= sb.empty;
			empty_b2 <= empty_b1;
			empty_b3 <= empty_b2;
			empty_b4 <= empty_b3;
			empty_b5 <= empty_b4;
		end
	end

	assign res_valid = valid_b5;
	assign lift      = lift_b5;
	assign drag      = drag_b5;
	assign empty     = empty_b5;

endmodule

// File: rtl/core/bilinear_table_interpolator.sv
// top level of the bilinear table interpolator
// Usage: configure mach_point_count and aoa_point_count over the cfg channel
// (cfg_ready is always high), then send beats on the input channel. Actions
// 0 to 3 load one breakpoint or one table entry and return nothing; action 4
// is a query and returns one beat with lift_coeff, drag_coeff and table_empty.
// A query beat passes through three stages of search and operand fetch, one
// stage per quotient bit of the fraction divider, then table read and four
// blend stages. Throughput: one beat per cycle while not stalled; every stage
// advances together.
// When the receiver holds out_stall with out_valid high, the whole pipeline
// freezes and in_stall goes high in the same cycle; nothing is dropped.
// Reset clears both counts to zero and empties the pipeline; breakpoints and
// table entries hold garbage until loaded, and a query then reports
// table_empty until both counts are nonzero.
`timescale 1ns / 1ps
module bilinear_table_interpolator import bti_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ACT_W-1:0]        action,
	input  logic [ROW_W-1:0]        row_index,
	input  logic [COL_W-1:0]        col_index,
	input  logic signed [VAL_W-1:0] write_value,
	input  logic signed [VAL_W-1:0] query_mach,
	input  logic signed [VAL_W-1:0] query_aoa,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] lift_coeff,
	output logic signed [VAL_W-1:0] drag_coeff,
	output logic                    table_empty,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CNT_W-1:0]        cfg_data
);

	logic             en, accept;
	logic [CNT_W-1:0] mach_cnt_q, aoa_cnt_q;
	logic [AX_CW-1:0] nm, na;
	pt_wr_t           mach_wr, aoa_wr;
	axis_res_t        mres, ares;
	sb_t              sb_in;

	// sideband, indexed by stage
	logic             sb_live_s [AXIS_LAT];
	sb_t              sb_s [AXIS_LAT];

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign accept    = in_valid && en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mach_cnt_q <= '0;
			aoa_cnt_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MACH_COUNT: mach_cnt_q <= cfg_data;
				CFG_AOA_COUNT:  aoa_cnt_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nm = (int'(mach_cnt_q) > MAX_MACH_POINTS) ? AX_CW'(MAX_MACH_POINTS)
							  : AX_CW'(mach_cnt_q);
	assign na = (int'(aoa_cnt_q) > MAX_AOA_POINTS) ? AX_CW'(MAX_AOA_POINTS)
							: AX_CW'(aoa_cnt_q);

	assign mach_wr.en   = accept && (action == ACT_MACH_PT)
			      && (32'(row_index) < MAX_MACH_POINTS);
	assign mach_wr.idx  = AX_IW'(row_index);
	assign mach_wr.data = write_value;
	assign aoa_wr.en    = accept && (action == ACT_AOA_PT)
			      && (32'(col_index) < MAX_AOA_POINTS);
	assign aoa_wr.idx   = AX_IW'(col_index);
	assign aoa_wr.data  = write_value;

	assign sb_in.action = action;
	assign sb_in.row    = row_index;
	assign sb_in.col    = col_index;
	assign sb_in.wv     = write_value;
	assign sb_in.empty  = (nm == '0) || (na == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AXIS_LAT; k++) begin
				sb_live_s[k] <= 1'b0;
			end
		end else if (en) begin
			sb_live_s[0] <= accept;
			for (int k = 1; k < AXIS_LAT; k++) begin
				sb_live_s[k] <= sb_live_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[0] <= sb_in;
			for (int k = 1; k < AXIS_LAT; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	bti_axis u_mach (
		.clk    (clk),
		.en     (en),
		.x      (query_mach),
		.n      (nm),
		.wr     (mach_wr),
		.res    (mres)
	);

	bti_axis u_aoa (
		.clk    (clk),
		.en     (en),
		.x      (query_aoa),
		.n      (na),
		.wr     (aoa_wr),
		.res    (ares)
	);

	bti_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.live      (sb_live_s[AXIS_LAT-1]),
		.sb        (sb_s[AXIS_LAT-1]),
		.mres      (mres),
		.ares      (ares),
		.res_valid (out_valid),
		.lift      (lift_coeff),
		.drag      (drag_coeff),
		.empty     (table_empty)
	);

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_empty |-> (lift_coeff == '0) && (drag_coeff == '0))
		else $error("empty table beat carries nonzero coefficients");

	a_accept_live: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sb_live_s[0])
		else $error("accepted beat not entered in the pipeline");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sb_live_s[AXIS_LAT-1]))
		else $error("pipeline moved while stalled");

endmodule
